// ===== design/tovn_pkg.sv =====
// Shared types and constants for the value-noise height block.
package tovn_pkg;

  localparam int NOISE_FRAC_BITS = 16;
  localparam int COORD_FRAC      = 24;
  localparam int FRAC_W          = NOISE_FRAC_BITS;

  localparam logic [1:0] REG_LOW_FREQ  = 2'd0;
  localparam logic [1:0] REG_HIGH_FREQ = 2'd1;
  localparam logic [1:0] REG_LOW_AMP   = 2'd2;
  localparam logic [1:0] REG_HIGH_AMP  = 2'd3;

  localparam logic [15:0] RST_LOW_FREQ  = 16'd786;
  localparam logic [15:0] RST_HIGH_FREQ = 16'd2621;
  localparam logic [15:0] RST_LOW_AMP   = 16'd23040;
  localparam logic [15:0] RST_HIGH_AMP  = 16'd7680;

  localparam logic [31:0] HASH_KX  = 32'd1619;
  localparam logic [31:0] HASH_KZ  = 32'd31337;
  localparam logic [31:0] HASH_K1  = 32'd15731;
  localparam logic [31:0] HASH_K2  = 32'd789221;
  localparam logic [31:0] HASH_K3  = 32'd1376312589;

  // One lattice split of both coordinates for one octave.
  typedef struct packed {
    logic [31:0]       ix;
    logic [31:0]       iz;
    logic [FRAC_W-1:0] tx;
    logic [FRAC_W-1:0] tz;
  } split_t;

  typedef struct packed {
    split_t      lo;
    split_t      hi;
    logic [15:0] lo_amp;
    logic [15:0] hi_amp;
  } job_t;

endpackage

// ===== design/tovn_front.sv =====
// Front end: scales the world point by both frequencies and splits it into lattice and fraction.
module tovn_front
  import tovn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] world_x,
  input  logic [31:0] world_z,
  input  logic [15:0] lo_freq,
  input  logic [15:0] hi_freq,
  input  logic [15:0] lo_amp,
  input  logic [15:0] hi_amp,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  logic        v_r;
  job_t        job_r;
  logic        adv;

  function automatic split_t do_split(input logic [31:0] x, input logic [31:0] z,
                                      input logic [15:0] f);
    logic signed [COORD_FRAC+31:0] px;
    logic signed [COORD_FRAC+31:0] pz;
    split_t s;
    px = $signed(x) * $signed({1'b0, f});
    pz = $signed(z) * $signed({1'b0, f});
    s.ix = px[COORD_FRAC+31:COORD_FRAC];
    s.iz = pz[COORD_FRAC+31:COORD_FRAC];
    s.tx = px[COORD_FRAC-1 -: FRAC_W];
    s.tz = pz[COORD_FRAC-1 -: FRAC_W];
    return s;
  endfunction

  assign adv      = !v_r || job_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      job_r.lo     <= do_split(world_x, world_z, lo_freq);
      job_r.hi     <= do_split(world_x, world_z, hi_freq);
      job_r.lo_amp <= lo_amp;
      job_r.hi_amp <= hi_amp;
    end
  end

  assign job_valid = v_r;
  assign job       = job_r;

endmodule

// ===== design/tovn_queue.sv =====
// Two-entry queue between the front end and the noise pipeline.
module tovn_queue
  import tovn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       wr;
  logic       rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (cnt_r <= 2'd2) else $error("queue count out of range");
    end
  end

  a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !rd) else $error("read from empty queue");
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !rd) |=> cnt_r == 2'd2) else $error("full queue lost an entry");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r) else $error("pointer mismatch");

endmodule

// ===== design/tovn_back.sv =====
// Back end: smoothstep, corner hashes, bilinear blend and amplitude sum, pipelined over the stages below.
module tovn_back
  import tovn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [16:0] height
);

  localparam int NST = 9;
  localparam logic [FRAC_W+1:0] THREE = (FRAC_W+2)'(3) << FRAC_W;

  typedef struct packed {
    logic [31:0] ix;
    logic [31:0] iz;
    logic [FRAC_W-1:0] wx;
    logic [FRAC_W-1:0] wz;
  } oct_t;

  logic        v_r [NST];
  logic        adv;

  // Stage 1: t squared.
  job_t        s1_r;
  logic [FRAC_W-1:0] t2_r [4];
  // Stage 2: eased weights and hash seeds.
  oct_t        s2_r [2];
  logic [15:0] amp2_r [2];
  // Stage 3: n = x*KX + z*KZ per corner, then shifted xor.
  logic [31:0] n3_r [8];
  logic [FRAC_W-1:0] w3_r [4];
  logic [15:0] amp3_r [2];
  // Stage 4: n*n.
  logic [31:0] n4_r [8];
  logic [31:0] sq4_r [8];
  logic [FRAC_W-1:0] w4_r [4];
  logic [15:0] amp4_r [2];
  // Stage 5: n*n*K1 + K2.
  logic [31:0] n4k_r [8];
  logic [31:0] k4k_r [8];
  logic [FRAC_W-1:0] w4k_r [4];
  logic [15:0] amp4k_r [2];
  // Stage 6: final hash.
  logic [15:0] h5_r [8];
  logic [FRAC_W-1:0] w5_r [4];
  logic [15:0] amp5_r [2];
  // Stage 7: x lerp.
  logic [15:0] a6_r [4];
  logic [FRAC_W-1:0] w6_r [2];
  logic [15:0] amp6_r [2];
  // Stage 8: z lerp.
  logic [15:0] v7_r [2];
  logic [15:0] amp7_r [2];
  // Stage 9: amplitude sum.
  logic [16:0] out_r;

  logic [FRAC_W-1:0] tsrc [4];

  function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                       input logic [FRAC_W-1:0] w);
    logic [FRAC_W+16:0] s;
    s = ({(FRAC_W+1)'(0), a} * ({1'b1, {FRAC_W{1'b0}}} - {1'b0, w}))
      + ({(FRAC_W+1)'(0), b} * {1'b0, w});
    return s[FRAC_W +: 16];
  endfunction

  assign adv       = !v_r[NST-1] || out_tready;
  assign job_ready = adv;
  assign tsrc[0] = job.lo.tx;
  assign tsrc[1] = job.lo.tz;
  assign tsrc[2] = job.hi.tx;
  assign tsrc[3] = job.hi.tz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= job_valid;
      for (int i = 1; i < NST; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [2*FRAC_W-1:0] sq;
    logic [2*FRAC_W+1:0] ez;
    logic [FRAC_W-1:0] tt [4];
    logic [31:0] ix, iz, n;
    logic [31:0] hh;
    logic [47:0] acc;
    if (adv) begin
      s1_r <= job;
      for (int i = 0; i < 4; i++) begin
        sq = tsrc[i] * tsrc[i];
        t2_r[i] <= sq[FRAC_W +: FRAC_W];
      end

      tt[0] = s1_r.lo.tx; tt[1] = s1_r.lo.tz; tt[2] = s1_r.hi.tx; tt[3] = s1_r.hi.tz;
      for (int i = 0; i < 4; i++) begin
        ez = {2'b0, t2_r[i]} * (THREE - {1'b0, tt[i], 1'b0});
        if (i % 2 == 0) s2_r[i/2].wx <= ez[FRAC_W +: FRAC_W];
        else            s2_r[i/2].wz <= ez[FRAC_W +: FRAC_W];
      end
      s2_r[0].ix <= s1_r.lo.ix; s2_r[0].iz <= s1_r.lo.iz;
      s2_r[1].ix <= s1_r.hi.ix; s2_r[1].iz <= s1_r.hi.iz;
      amp2_r[0] <= s1_r.lo_amp;
      amp2_r[1] <= s1_r.hi_amp;

      // Corner order within an octave: (x,z), (x+1,z), (x,z+1), (x+1,z+1).
      for (int c = 0; c < 8; c++) begin
        ix = s2_r[c/4].ix + 32'(c % 2);
        iz = s2_r[c/4].iz + 32'((c/2) % 2);
        n  = ix * HASH_KX + iz * HASH_KZ;
        n3_r[c] <= (n << 13) ^ n;
      end
      w3_r[0] <= s2_r[0].wx; w3_r[1] <= s2_r[0].wz;
      w3_r[2] <= s2_r[1].wx; w3_r[3] <= s2_r[1].wz;
      amp3_r <= amp2_r;

      for (int c = 0; c < 8; c++) begin
        n4_r[c]  <= n3_r[c];
        sq4_r[c] <= n3_r[c] * n3_r[c];
      end
      w4_r <= w3_r;
      amp4_r <= amp3_r;

      for (int c = 0; c < 8; c++) begin
        n4k_r[c] <= n4_r[c];
        k4k_r[c] <= sq4_r[c] * HASH_K1 + HASH_K2;
      end
      w4k_r <= w4_r;
      amp4k_r <= amp4_r;

      for (int c = 0; c < 8; c++) begin
        hh = n4k_r[c] * k4k_r[c] + HASH_K3;
        h5_r[c] <= hh[30:15];
      end
      w5_r <= w4k_r;
      amp5_r <= amp4k_r;

      for (int o = 0; o < 2; o++) begin
        a6_r[2*o]   <= lerp(h5_r[4*o],   h5_r[4*o+1], w5_r[2*o]);
        a6_r[2*o+1] <= lerp(h5_r[4*o+2], h5_r[4*o+3], w5_r[2*o]);
        w6_r[o]     <= w5_r[2*o+1];
      end
      amp6_r <= amp5_r;

      for (int o = 0; o < 2; o++) begin
        v7_r[o] <= lerp(a6_r[2*o], a6_r[2*o+1], w6_r[o]);
      end
      amp7_r <= amp6_r;

      acc = {32'd0, v7_r[0]} * {32'd0, amp7_r[0]} + {32'd0, v7_r[1]} * {32'd0, amp7_r[1]};
      out_r <= acc[32:16];
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign height     = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NST-1] && !out_tready) |=> v_r[NST-1] && $stable(out_r))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NST-1] |-> job_ready) else $error("pipeline stalled with empty output");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_ready) |=> v_r[0]) else $error("accepted job lost");

endmodule

// ===== design/two_octave_value_noise_height.sv =====
// Top level of the two-octave value-noise height generator.
// Path from input request to result: front-end register, queue, then the 9 noise stages.
// Throughput: one request per cycle unless stalled; the noise hash multipliers are fully staged.
// Backpressure on the output stalls the noise pipeline; the queue decouples the front end.
// Reset (synchronous, active low) empties the pipeline and queue and restores register defaults.
module two_octave_value_noise_height
  import tovn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] world_x, [63:32] world_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] height, rest zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] lo_freq_r, hi_freq_r, lo_amp_r, hi_amp_r;
  logic        fj_valid, fj_ready, qj_valid, qj_ready;
  job_t        fj, qj;
  logic [16:0] height;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_freq_r <= RST_LOW_FREQ;
      hi_freq_r <= RST_HIGH_FREQ;
      lo_amp_r  <= RST_LOW_AMP;
      hi_amp_r  <= RST_HIGH_AMP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_FREQ:  lo_freq_r <= cfg_data;
        REG_HIGH_FREQ: hi_freq_r <= cfg_data;
        REG_LOW_AMP:   lo_amp_r  <= cfg_data;
        REG_HIGH_AMP:  hi_amp_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  tovn_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .world_x(in_tdata[31:0]), .world_z(in_tdata[63:32]),
    .lo_freq(lo_freq_r), .hi_freq(hi_freq_r), .lo_amp(lo_amp_r), .hi_amp(hi_amp_r),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  tovn_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_data(qj)
  );

  tovn_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .height(height)
  );

  assign out_tdata = {7'd0, height};

endmodule

// ===== tb/two_octave_value_noise_height_tb.sv =====
// Testbench for the two-octave value-noise height block: directed and random points checked against a local predictor.
module two_octave_value_noise_height_tb;
  import tovn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int LATENCY     = 11;

  // Configuration register file as the block sees it.
  typedef struct {
    logic [15:0] lo_freq;
    logic [15:0] hi_freq;
    logic [15:0] lo_amp;
    logic [15:0] hi_amp;
  } noise_cfg_t;

  // Predicts heights and keeps the queue of heights still owed by the block.
  class height_scoreboard;
    noise_cfg_t  regs;
    logic [16:0] owed_heights[$];
    int          errors;

    function new();
      regs.lo_freq = RST_LOW_FREQ;
      regs.hi_freq = RST_HIGH_FREQ;
      regs.lo_amp  = RST_LOW_AMP;
      regs.hi_amp  = RST_HIGH_AMP;
      errors = 0;
    endfunction

    function logic [15:0] lattice_hash(logic [31:0] cx, logic [31:0] cz);
      logic [31:0] n;
      n = cx * 32'd1619 + cz * 32'd31337;
      n = (n << 13) ^ n;
      n = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
      return n[30:15];
    endfunction

    function logic [63:0] smooth(logic [63:0] t);
      logic [63:0] t2;
      t2 = (t * t) >> NOISE_FRAC_BITS;
      return (t2 * ((64'd3 << NOISE_FRAC_BITS) - 2 * t)) >> NOISE_FRAC_BITS;
    endfunction

    function logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] w);
      return (a * ((64'd1 << NOISE_FRAC_BITS) - w) + b * w) >> NOISE_FRAC_BITS;
    endfunction

    function logic [63:0] octave_value(logic [31:0] x, logic [31:0] z, logic [15:0] freq);
      logic signed [63:0] px, pz;
      logic [31:0]        ix, iz;
      logic [63:0]        wx, wz, a, b;
      px = $signed(x) * $signed({48'd0, freq});
      pz = $signed(z) * $signed({48'd0, freq});
      ix = px[55:24];
      iz = pz[55:24];
      wx = smooth(64'(px[23:0] >> (COORD_FRAC - NOISE_FRAC_BITS)));
      wz = smooth(64'(pz[23:0] >> (COORD_FRAC - NOISE_FRAC_BITS)));
      a = blend(lattice_hash(ix, iz), lattice_hash(ix + 1, iz), wx);
      b = blend(lattice_hash(ix, iz + 1), lattice_hash(ix + 1, iz + 1), wx);
      return blend(a, b, wz);
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] z);
      logic [63:0] h;
      h = (octave_value(x, z, regs.lo_freq) * regs.lo_amp
           + octave_value(x, z, regs.hi_freq) * regs.hi_amp) >> 16;
      owed_heights.push_back(h[16:0]);
    endfunction

    function void check_height(logic [23:0] tdata);
      logic [16:0] want;
      if (owed_heights.size() == 0) begin
        $error("height: unexpected result %0d", tdata[16:0]);
        errors++;
        return;
      end
      want = owed_heights.pop_front();
      if (tdata[16:0] !== want) begin
        $error("height: expected %0d, actual %0d", want, tdata[16:0]);
        errors++;
      end
      if (tdata[23:17] !== 7'd0) begin
        $error("pad: expected 0, actual %0h", tdata[23:17]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_LOW_FREQ;
  logic [15:0] cfg_data = '0;

  height_scoreboard sb = new();
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  two_octave_value_noise_height dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver side: random ready gaps, plus one long hold-off on request.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (200) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_height(out_tdata);
  end

  // Watchdog: cycles without any accepted request on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else if (sb.owed_heights.size() != 0 || !stim_done)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("two_octave_value_noise_height: mismatch");
      $finish;
    end
  end

  // The valid line stays high after a request so that the next one can follow at once.
  task automatic send_point(logic [31:0] x, logic [31:0] z, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_point(x, z);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.owed_heights.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOW_FREQ:  sb.regs.lo_freq = val;
      REG_HIGH_FREQ: sb.regs.hi_freq = val;
      REG_LOW_AMP:   sb.regs.lo_amp  = val;
      REG_HIGH_AMP:  sb.regs.hi_amp  = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 65535) - 32768;
      2: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 300)
                                           : 32'h80000000 + $urandom_range(0, 300);
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[8] = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff,
                                 32'h80000000, 32'h100, 32'hffffff00, 32'h55aa33cc};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: coordinate extremes at reset settings, then zero frequency, then full-scale frequencies and amplitudes.
    for (int i = 0; i < 8; i++) send_point(edge_vals[i], edge_vals[7 - i]);
    send_point(32'hffffffff, 32'hffffffff);
    send_point(32'h7fffffff, 32'h80000000);
    drain();
    write_reg(REG_LOW_FREQ, 16'h0);
    write_reg(REG_HIGH_FREQ, 16'h0);
    for (int i = 0; i < 4; i++) send_point(edge_vals[i + 2], edge_vals[i]);
    drain();
    write_reg(REG_LOW_FREQ, 16'hffff);
    write_reg(REG_HIGH_FREQ, 16'hffff);
    write_reg(REG_LOW_AMP, 16'hffff);
    write_reg(REG_HIGH_AMP, 16'hffff);
    for (int i = 0; i < 8; i++) send_point(edge_vals[i], edge_vals[(i + 3) % 8]);
    drain();

    // Random phases, each under fresh register settings.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_LOW_FREQ, phase == 1 ? 16'h0 : 16'($urandom()));
      write_reg(REG_HIGH_FREQ, 16'($urandom()));
      write_reg(REG_LOW_AMP, phase == 2 ? 16'h0 : 16'($urandom()));
      write_reg(REG_HIGH_AMP, phase == 3 ? 16'hffff : 16'($urandom()));
      if (phase == 4) begin
        long_hold = 1'b1;
        for (int i = 0; i < 60; i++) send_point(rand_coord(), rand_coord(), 1'b1);
      end
      for (int i = 0; i < 135; i++) begin
        if (i % 40 == 0) begin
          in_tvalid <= 1'b0;
          @(negedge clk);
          while (sb.owed_heights.size() != 0) @(negedge clk);
        end
        send_point(rand_coord(), rand_coord(), (i / 20) % 3 == 0);
      end
      drain();
    end
    write_reg(REG_LOW_FREQ, RST_LOW_FREQ);
    write_reg(REG_HIGH_FREQ, RST_HIGH_FREQ);
    write_reg(REG_LOW_AMP, RST_LOW_AMP);
    write_reg(REG_HIGH_AMP, RST_HIGH_AMP);
    for (int i = 0; i < 30; i++) send_point(rand_coord(), rand_coord());
    stim_done = 1'b1;
    drain();

    if (sb.errors == 0 && sb.owed_heights.size() == 0)
      $display("two_octave_value_noise_height: match");
    else
      $display("two_octave_value_noise_height: mismatch");
    $finish;
  end

endmodule
